>>> design/fpta_pkg.sv
// ----------------------------------------------------------------------------
// fpta_pkg: shared types and constants of the truncating fp32 adder
// Holds field masks, the top fraction position and the stage payload structs.
// ----------------------------------------------------------------------------
`default_nettype none
package fpta_pkg;
    localparam logic [31:0] MAG_MASK  = 32'h7FFF_FFFF;
    localparam logic [22:0] FRAC_MASK = 23'h7F_FFFF;
    localparam logic [4:0]  TOP_POS   = 5'd22;

    // aligned operands after stage 1
    typedef struct packed {
        logic        sign;
        logic        sub;
        logic [7:0]  ebig;
        logic [23:0] sig_big;
        logic [23:0] sig_small;
    } align_t;

    // sum after stage 2
    typedef struct packed {
        logic        sign;
        logic [7:0]  ebig;
        logic [24:0] sum;
    } addsum_t;

    // normalize info after stage 3
    typedef struct packed {
        logic        sign;
        logic [7:0]  ebig;
        logic [24:0] sum;
        logic [4:0]  shift;
    } lzd_t;
endpackage
`default_nettype wire

>>> design/fpta_align.sv
// ----------------------------------------------------------------------------
// fpta_align: operand swap and significand alignment
// Picks the larger magnitude, adds hidden bits, shifts the smaller right.
// ----------------------------------------------------------------------------
`default_nettype none
module fpta_align (
    input  wire logic [31:0]      operand_a,
    input  wire logic [31:0]      operand_b,
    output fpta_pkg::align_t      align
);
    import fpta_pkg::*;

    logic [31:0] big;
    logic [31:0] small_op;
    logic [7:0]  esmall;
    logic [7:0]  exp_dist;
    logic [23:0] sig_s;

    // swap on magnitude and align
    always_comb
    begin
        if ((operand_b & MAG_MASK) > (operand_a & MAG_MASK))
        begin
            big      = operand_b;
            small_op = operand_a;
        end
        else
        begin
            big      = operand_a;
            small_op = operand_b;
        end
        esmall          = small_op[30:23];
        align.sign      = big[31];
        align.sub       = operand_a[31] ^ operand_b[31];
        align.ebig      = big[30:23];
        align.sig_big   = {(big[30:23] != 8'd0), big[22:0]};
        sig_s           = {(esmall != 8'd0), small_op[22:0]};
        exp_dist        = big[30:23] - esmall;
        align.sig_small = (exp_dist >= 8'd32) ? 24'd0 : (sig_s >> exp_dist[4:0]);
    end
endmodule
`default_nettype wire

>>> design/fpta_lzd.sv
// ----------------------------------------------------------------------------
// fpta_lzd: leading-one detect on sum bits 23..2
// Gives shift = 22 - position, position of zero taken as 0.
// ----------------------------------------------------------------------------
`default_nettype none
module fpta_lzd (
    input  wire fpta_pkg::addsum_t  sum_in,
    output fpta_pkg::lzd_t          lzd
);
    import fpta_pkg::*;

    logic [22:0] norm;
    logic [4:0]  pos;

    // priority search from low to high, last hit wins
    always_comb
    begin
        norm = sum_in.sum[23:1];
        pos  = 5'd0;
        for (int i = 1; i < 23; i++)
        begin
            if (norm[i])
                pos = 5'(i);
        end
        lzd.sign  = sum_in.sign;
        lzd.ebig  = sum_in.ebig;
        lzd.sum   = sum_in.sum;
        lzd.shift = TOP_POS - pos;
    end
endmodule
`default_nettype wire

>>> design/fp32_truncating_adder.sv
// ----------------------------------------------------------------------------
// fp32_truncating_adder: truncating single-precision adder
// Four-stage pipeline: align, add, leading-one detect, normalize and pack.
// ----------------------------------------------------------------------------
// Path: an accepted input passes st1_reg, st2_reg, st3_reg and res_reg before m_tvalid.
// Throughput: one item per cycle; a stall holds every stage in place.
// Reset: rst_n clears all stage valid bits; payload registers are not reset.
`default_nettype none
module fp32_truncating_adder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // sum_word [31:0]
);
    import fpta_pkg::*;

    logic    v1_reg, v2_reg, v3_reg, v4_reg;
    align_t  st1_next, st1_reg;
    addsum_t st2_next, st2_reg;
    lzd_t    st3_next, st3_reg;
    logic [31:0] res_next, res_reg;
    logic    adv;

    // whole pipe advances when the output slot is free
    assign adv      = m_tready || !v4_reg;
    assign s_tready = adv;
    assign m_tvalid = v4_reg;
    assign m_tdata  = res_reg;

    fpta_align u_align (
        .operand_a (s_tdata[31:0]),
        .operand_b (s_tdata[63:32]),
        .align     (st1_next)
    );

    // add or subtract significands
    always_comb
    begin
        st2_next.sign = st1_reg.sign;
        st2_next.ebig = st1_reg.ebig;
        if (st1_reg.sub)
            st2_next.sum = {1'b0, st1_reg.sig_big} - {1'b0, st1_reg.sig_small};
        else
            st2_next.sum = {1'b0, st1_reg.sig_big} + {1'b0, st1_reg.sig_small};
    end

    fpta_lzd u_lzd (
        .sum_in (st2_reg),
        .lzd    (st3_next)
    );

    // normalize and pack
    always_comb
    begin
        logic [8:0]  e;
        logic [22:0] f;
        logic [24:0] sh;
        sh = st3_reg.sum << st3_reg.shift;
        if ({3'd0, st3_reg.ebig} < {3'd0, st3_reg.shift})
        begin
            e = 9'd0;
            f = 23'd0;
        end
        else if (st3_reg.sum[24])
        begin
            e = {1'b0, st3_reg.ebig} + 9'd1;
            f = st3_reg.sum[23:1];
        end
        else
        begin
            e = {1'b0, st3_reg.ebig} - {4'd0, st3_reg.shift};
            f = sh[22:0] & FRAC_MASK;
        end
        res_next = {st3_reg.sign ^ e[8], e[7:0], f};
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st3_reg <= st3_next;
            res_reg <= res_next;
        end
    end

    // a stalled output holds its word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed under stall");

    // an accepted item enters stage 1 on the next cycle
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted item lost in stage 1");

    // underflow packs zero exponent and fraction
    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && adv && ({3'd0, st3_reg.ebig} < {3'd0, st3_reg.shift})
        |=> m_tdata[30:0] == 31'd0)
        else $error("underflow not flushed");
endmodule
`default_nettype wire
